// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== sv/mf3x3_pkg.sv =====
package mf3x3_pkg;

    // default sizes
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int PIXEL_BITS_DEF = 8;

    // config port
    localparam int CFG_BITS       = 12;
    localparam int CFG_INDEX_BITS = 1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    localparam int WIDTH_REG_BITS  = 11;
    localparam int HEIGHT_REG_BITS = 12;
    localparam int WIDTH_RESET     = 640;
    localparam int HEIGHT_RESET    = 480;

    // result tag fields
    localparam int ROW_BITS     = 12;
    localparam int COL_OUT_BITS = 10;

    // results a pixel can cause, in emit order; bit 0 = right edge, bit 1 = lower row
    localparam int NUM_RES       = 4;
    localparam int RES_UP_MID    = 0;
    localparam int RES_UP_RIGHT  = 1;
    localparam int RES_LOW_MID   = 2;
    localparam int RES_LOW_RIGHT = 3;

    typedef struct packed {
        logic [ROW_BITS-1:0]     row;
        logic [COL_OUT_BITS-1:0] column;
        logic                    last;
    } t_tag;

endpackage

// ===== sv/mf3x3_ram.sv =====
module mf3x3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds until the next read
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/mf3x3_median.sv =====
// 3-stage median-of-9: sort rows, combine, final median of three.
module mf3x3_median #(
    parameter int PIXEL_BITS = mf3x3_pkg::PIXEL_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [8:0][PIXEL_BITS-1:0]   i_pix,
    input  mf3x3_pkg::t_tag              i_tag,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [PIXEL_BITS-1:0]        o_median,
    output mf3x3_pkg::t_tag              o_tag
);

    typedef logic [PIXEL_BITS-1:0]       t_pix;
    typedef logic [2:0][PIXEL_BITS-1:0]  t_tri;

    function automatic t_tri sort3(input t_pix a, input t_pix b, input t_pix c);
        t_pix l1, h1, t, lo, md, hi;
        l1 = (a < b) ? a : b;
        h1 = (a < b) ? b : a;
        lo = (l1 < c) ? l1 : c;
        t  = (l1 < c) ? c : l1;
        md = (t < h1) ? t : h1;
        hi = (t < h1) ? h1 : t;
        return {hi, md, lo};
    endfunction

    logic        r_a_valid, r_b_valid, r_c_valid;
    t_tri        r_a [3];
    t_tri        n_a [3];
    t_pix        r_b_lo, r_b_md, r_b_hi;
    t_pix        n_b_lo, n_b_md, n_b_hi;
    t_tri        b_mids, c_sorted;
    t_pix        r_med;
    mf3x3_pkg::t_tag r_a_tag, r_b_tag, r_c_tag;
    logic        c_rdy, b_rdy;

    assign c_rdy   = !r_c_valid || i_ready;
    assign b_rdy   = !r_b_valid || c_rdy;
    assign o_ready = !r_a_valid || b_rdy;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_a[i] = sort3(i_pix[3*i], i_pix[3*i+1], i_pix[3*i+2]);
        end
    end

    // max of row minima, median of row medians, min of row maxima
    always_comb begin
        n_b_lo = r_a[0][0];
        n_b_hi = r_a[0][2];
        for (int i = 1; i < 3; i++) begin
            if (r_a[i][0] > n_b_lo) begin
                n_b_lo = r_a[i][0];
            end
            if (r_a[i][2] < n_b_hi) begin
                n_b_hi = r_a[i][2];
            end
        end
        b_mids = sort3(r_a[0][1], r_a[1][1], r_a[2][1]);
        n_b_md = b_mids[1];
    end

    assign c_sorted = sort3(r_b_lo, r_b_md, r_b_hi);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_a_valid <= i_valid;
            end
            if (b_rdy) begin
                r_b_valid <= r_a_valid;
            end
            if (c_rdy) begin
                r_c_valid <= r_b_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_a     <= n_a;
            r_a_tag <= i_tag;
        end
        if (b_rdy && r_a_valid) begin
            r_b_lo  <= n_b_lo;
            r_b_md  <= n_b_md;
            r_b_hi  <= n_b_hi;
            r_b_tag <= r_a_tag;
        end
        if (c_rdy && r_b_valid) begin
            r_med   <= c_sorted[1];
            r_c_tag <= r_b_tag;
        end
    end

    assign o_valid  = r_c_valid;
    assign o_median = r_med;
    assign o_tag    = r_c_tag;

endmodule

// ===== sv/median_filter_3x3_core.sv =====
// Streaming 3x3 median filter with edge replication.
// Input channel (i_in_valid / o_in_ready): grayscale pixels in raster order,
// one per transfer. Output channel (o_out_valid / i_out_ready): one filtered
// pixel per transfer, tagged with row and column; o_run_last marks the final
// result caused by a given input pixel. Results for row r-1 come out while
// row r streams in; the last row is filtered while it arrives. Row 0 gives
// no results.
// Throughput: one pixel per cycle in most rows while the receiver keeps up.
// The result issue stage emits one result per cycle while the median
// pipeline is ready, so a pixel that causes two results (last column, and
// every pixel but the first of the last row), or the last pixel of a frame,
// with four, holds the issue stage until its last result is issued.
// Config (i_cfg_we) sets image width/height and restarts the frame; write it
// only while the block is idle. Line stores are not cleared.
// Reset (synchronous, active low): counters at the frame start, pipeline
// empty, 640x480 image. A stalled receiver backs up the median pipeline,
// then the issue stage, then o_in_ready drops; nothing is lost.
`include "assert_macros.svh"

module median_filter_3x3_core #(
    parameter int MAX_WIDTH  = mf3x3_pkg::MAX_WIDTH_DEF,
    parameter int PIXEL_BITS = mf3x3_pkg::PIXEL_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration
    input  logic                                  i_cfg_we,
    input  logic [mf3x3_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [mf3x3_pkg::CFG_BITS-1:0]        i_cfg_data,
    // pixel input
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [PIXEL_BITS-1:0]                 i_pixel_value,
    // results
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [mf3x3_pkg::ROW_BITS-1:0]        o_out_row,
    output logic [mf3x3_pkg::COL_OUT_BITS-1:0]    o_out_column,
    output logic [PIXEL_BITS-1:0]                 o_median_value,
    output logic                                  o_run_last
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RB = mf3x3_pkg::ROW_BITS;
    localparam int NR = mf3x3_pkg::NUM_RES;
    localparam int WIDTH_EFF_RESET =
        (mf3x3_pkg::WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : mf3x3_pkg::WIDTH_RESET;
    localparam logic [CW-1:0] COL_LAST_RESET = CW'(WIDTH_EFF_RESET - 1);
    localparam logic [RB-1:0] ROW_LAST_RESET = RB'(mf3x3_pkg::HEIGHT_RESET - 1);

    // ---------------------------------------------------------------
    // Config: stored as index of the last column / last row
    // ---------------------------------------------------------------
    logic [CW-1:0] r_col_last, n_col_last;
    logic [RB-1:0] r_row_last, n_row_last;
    logic [mf3x3_pkg::WIDTH_REG_BITS-1:0]  cfg_w;
    logic [mf3x3_pkg::HEIGHT_REG_BITS-1:0] cfg_h;

    assign cfg_w = i_cfg_data[mf3x3_pkg::WIDTH_REG_BITS-1:0];
    assign cfg_h = i_cfg_data[mf3x3_pkg::HEIGHT_REG_BITS-1:0];

    always_comb begin
        n_col_last = r_col_last;
        n_row_last = r_row_last;
        unique case (i_cfg_index)
            mf3x3_pkg::CFG_IMAGE_WIDTH: begin
                // below 2 -> 2, above store capacity -> capacity
                if (cfg_w < mf3x3_pkg::WIDTH_REG_BITS'(2)) begin
                    n_col_last = CW'(1);
                end else if (int'(cfg_w) > MAX_WIDTH) begin
                    n_col_last = CW'(MAX_WIDTH - 1);
                end else begin
                    n_col_last = CW'(cfg_w - mf3x3_pkg::WIDTH_REG_BITS'(1));
                end
            end
            mf3x3_pkg::CFG_IMAGE_HEIGHT: begin
                if (cfg_h < mf3x3_pkg::HEIGHT_REG_BITS'(2)) begin
                    n_row_last = RB'(1);
                end else begin
                    n_row_last = RB'(cfg_h - mf3x3_pkg::HEIGHT_REG_BITS'(1));
                end
            end
            default: begin
                n_col_last = r_col_last;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Stage 0: input transfer, position counters, line store read
    // ---------------------------------------------------------------
    logic          in_xfer;
    logic          s1_adv;
    logic          s2_take;
    logic          r_s1_valid;
    logic [CW-1:0] r_col;
    logic [RB-1:0] r_row;

    assign in_xfer    = i_in_valid && o_in_ready;
    assign o_in_ready = !r_s1_valid || s2_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_last <= COL_LAST_RESET;
            r_row_last <= ROW_LAST_RESET;
            r_col      <= '0;
            r_row      <= '0;
        end else if (i_cfg_we) begin
            // any config write restarts the frame
            r_col_last <= n_col_last;
            r_row_last <= n_row_last;
            r_col      <= '0;
            r_row      <= '0;
        end else if (in_xfer) begin
            if (r_col == r_col_last) begin
                r_col <= '0;
                r_row <= (r_row == r_row_last) ? '0 : r_row + RB'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: line store data back; write-back and window shift.
    // The next read of this column is at least two transfers away
    // (width >= 2) and stage 0 is held while stage 1 waits, so the
    // write always lands before the entry is read again.
    // ---------------------------------------------------------------
    logic [PIXEL_BITS-1:0] r_s1_pix;
    logic [CW-1:0]         r_s1_col;
    logic [RB-1:0]         r_s1_row;
    logic [PIXEL_BITS-1:0] older_rd, newer_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_xfer) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_pix <= i_pixel_value;
            r_s1_col <= r_col;
            r_s1_row <= r_row;
        end
    end

    // older row keeps what was the newer row; newer row takes the pixel
    mf3x3_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_older (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1_col),
        .i_wdata (newer_rd),
        .i_re    (in_xfer),
        .i_raddr (r_col),
        .o_rdata (older_rd)
    );

    mf3x3_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_newer (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1_col),
        .i_wdata (r_s1_pix),
        .i_re    (in_xfer),
        .i_raddr (r_col),
        .o_rdata (newer_rd)
    );

    // window rows: 0 = older, 1 = newer, 2 = current; columns oldest first
    logic [PIXEL_BITS-1:0] r_win [3][3];
    logic [PIXEL_BITS-1:0] n_win [3][3];
    logic [PIXEL_BITS-1:0] nv    [3];
    logic                  s1_c0, s1_clast, s1_rfirst, s1_rlast;
    logic [NR-1:0]         s1_mask;

    assign nv[0] = older_rd;
    assign nv[1] = newer_rd;
    assign nv[2] = r_s1_pix;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (s1_c0) begin
                // row start: replicate the left edge
                n_win[i][0] = nv[i];
                n_win[i][1] = nv[i];
            end else begin
                n_win[i][0] = r_win[i][1];
                n_win[i][1] = r_win[i][2];
            end
            n_win[i][2] = nv[i];
        end
    end

    assign s1_c0     = (r_s1_col == '0);
    assign s1_clast  = (r_s1_col == r_col_last);
    assign s1_rfirst = (r_s1_row == '0);
    assign s1_rlast  = (r_s1_row == r_row_last);

    always_comb begin
        s1_mask = '0;
        s1_mask[mf3x3_pkg::RES_UP_MID]    = !s1_rfirst && !s1_c0;
        s1_mask[mf3x3_pkg::RES_UP_RIGHT]  = !s1_rfirst && s1_clast;
        s1_mask[mf3x3_pkg::RES_LOW_MID]   = s1_rlast && !s1_c0;
        s1_mask[mf3x3_pkg::RES_LOW_RIGHT] = s1_rlast && s1_clast;
    end

    assign s1_adv = r_s1_valid && s2_take;

    // ---------------------------------------------------------------
    // Stage 2: result issue. Holds the window and a mask of pending
    // results; hands one per cycle to the median pipeline while it is ready.
    // ---------------------------------------------------------------
    logic [NR-1:0]  r_job_mask;
    logic [RB-1:0]  r_job_row;
    logic [CW-1:0]  r_job_col;
    logic           r_job_top_mid;    // row 1: no row above row 0
    logic [1:0]     sel_k;
    logic           sel_right, sel_low;
    logic [NR-1:0]  sel_bit;
    logic           job_single;
    logic           med_ready;
    logic           issue;
    logic [PIXEL_BITS-1:0]          row_a [3];
    logic [PIXEL_BITS-1:0]          row_b [3];
    logic [8:0][PIXEL_BITS-1:0]     med_pix;
    logic [CW-1:0]                  sel_col;
    mf3x3_pkg::t_tag                sel_tag;
    mf3x3_pkg::t_tag                out_tag;

    always_comb begin
        if (r_job_mask[mf3x3_pkg::RES_UP_MID]) begin
            sel_k = 2'(mf3x3_pkg::RES_UP_MID);
        end else if (r_job_mask[mf3x3_pkg::RES_UP_RIGHT]) begin
            sel_k = 2'(mf3x3_pkg::RES_UP_RIGHT);
        end else if (r_job_mask[mf3x3_pkg::RES_LOW_MID]) begin
            sel_k = 2'(mf3x3_pkg::RES_LOW_MID);
        end else begin
            sel_k = 2'(mf3x3_pkg::RES_LOW_RIGHT);
        end
    end

    assign sel_right  = sel_k[0];
    assign sel_low    = sel_k[1];
    assign sel_bit    = NR'(1) << sel_k;
    assign job_single = ((r_job_mask & (r_job_mask - NR'(1))) == '0);

    assign issue   = (r_job_mask != '0) && med_ready;
    assign s2_take = (r_job_mask == '0) || (job_single && med_ready);

    // neighborhood: rows clamp at top/bottom, right column clamps
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            row_a[j] = (sel_low || r_job_top_mid) ? r_win[1][j] : r_win[0][j];
            row_b[j] = sel_low ? r_win[2][j] : r_win[1][j];
        end
        med_pix[0] = sel_right ? row_a[1] : row_a[0];
        med_pix[1] = sel_right ? row_a[2] : row_a[1];
        med_pix[2] = row_a[2];
        med_pix[3] = sel_right ? row_b[1] : row_b[0];
        med_pix[4] = sel_right ? row_b[2] : row_b[1];
        med_pix[5] = row_b[2];
        med_pix[6] = sel_right ? r_win[2][1] : r_win[2][0];
        med_pix[7] = sel_right ? r_win[2][2] : r_win[2][1];
        med_pix[8] = r_win[2][2];
    end

    always_comb begin
        sel_col        = sel_right ? r_job_col : r_job_col - CW'(1);
        sel_tag.row    = sel_low ? r_job_row : r_job_row - RB'(1);
        sel_tag.column = mf3x3_pkg::COL_OUT_BITS'(sel_col);
        sel_tag.last   = ((r_job_mask & ~sel_bit) == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_mask <= '0;
        end else if (s1_adv) begin
            r_job_mask <= s1_mask;
        end else if (issue) begin
            r_job_mask <= r_job_mask & ~sel_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_win         <= n_win;
            r_job_row     <= r_s1_row;
            r_job_col     <= r_s1_col;
            r_job_top_mid <= (r_s1_row == RB'(1));
        end
    end

    // ---------------------------------------------------------------
    // Median pipeline with output register
    // ---------------------------------------------------------------
    mf3x3_median #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_median (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_job_mask != '0),
        .o_ready  (med_ready),
        .i_pix    (med_pix),
        .i_tag    (sel_tag),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_median (o_median_value),
        .o_tag    (out_tag)
    );

    assign o_out_row    = out_tag.row;
    assign o_out_column = out_tag.column;
    assign o_run_last   = out_tag.last;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    logic job_low;

    assign job_low = r_job_mask[mf3x3_pkg::RES_LOW_MID] || r_job_mask[mf3x3_pkg::RES_LOW_RIGHT];

    `ASSERT_NEXT(a_xfer_fills_s1, i_clk, i_rst_n, in_xfer, r_s1_valid)
    `ASSERT_IMPL(a_col_in_range, i_clk, i_rst_n, 1'b1, r_col <= r_col_last)
    `ASSERT_IMPL(a_low_only_last_row, i_clk, i_rst_n, job_low, r_job_row == r_row_last)

endmodule
